// ===== src/stb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int ID_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int VAL_W      = 16;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_READ  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_START = 3'd3,
		CMD_STOP  = 3'd4,
		CMD_CLEAR = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_READ  = 2'd1,
		ST_BAD_WRITE = 2'd2,
		ST_BAD_CMD   = 2'd3
	} status_t;

endpackage

// ===== src/soft_timer_bank_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_timer_bank_unit
// Bank of 16-bit down-counters held in a RAM, driven by tick commands.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | cmd, timer_id, write_value
//  out     | output    | out_valid / out_stall | read_value, status
//
//  One request at a time. Write, start, stop, clear, bad requests and ticks
//  while stopped go IDLE to DONE; a read passes READ for the registered RAM
//  read; a running tick walks TICK, one RAM entry read per cycle, written
//  back decremented if nonzero. Reset and clear only drop per-entry valid
//  bits; invalid entries read zero. A stalled result holds in the output
//  register; a finished request waits in DONE until that register frees up.
// ----------------------------------------------------------------------------
module soft_timer_bank_unit
	import stb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  timer_id,
	input  logic [15:0] write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] read_value,
	output logic [1:0]  status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_TICK,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic                    running_q;
	logic [NUM_TIMERS-1:0]   valid_q;
	logic [ID_W-1:0]         idx_q;
	logic [VAL_W-1:0]        res_value_q;
	status_t                 res_status_q;
	logic                    out_valid_q;
	logic [VAL_W-1:0]        read_value_q;
	status_t                 status_q;

	logic                    accept;
	logic                    id_ok;
	logic [ID_W-1:0]         id;
	logic                    ram_we;
	logic [ID_W-1:0]         ram_waddr;
	logic [VAL_W-1:0]        ram_wdata;
	logic [ID_W-1:0]         ram_raddr;
	logic [VAL_W-1:0]        ram_rdata;
	logic [VAL_W-1:0]        cur_value;
	logic                    last_idx;
	logic                    out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign id_ok     = (timer_id < 8'(NUM_TIMERS));
	assign id        = timer_id[ID_W-1:0];
	assign cur_value = valid_q[idx_q] ? ram_rdata : '0;
	assign last_idx  = (idx_q == ID_W'(NUM_TIMERS - 1));
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = cur_value - VAL_W'(1);
		ram_raddr = id;
		if (state_q == S_TICK) begin
			ram_raddr = idx_q + ID_W'(1);
			ram_we    = (cur_value != '0);
		end else if (accept && cmd_t'(cmd) == CMD_TICK) begin
			ram_raddr = '0;
		end else if (accept && cmd_t'(cmd) == CMD_WRITE && id_ok) begin
			ram_we    = 1'b1;
			ram_waddr = id;
			ram_wdata = write_value;
		end
	end

	stb_ram #(
		.WIDTH (VAL_W),
		.DEPTH (NUM_TIMERS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			running_q    <= 1'b0;
			valid_q      <= '0;
			idx_q        <= '0;
			res_value_q  <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			read_value_q <= '0;
			status_q     <= ST_OK;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_value_q  <= '0;
						res_status_q <= ST_OK;
						idx_q        <= id;
						state_q      <= S_DONE;
						unique case (cmd_t'(cmd))
							CMD_TICK: begin
								if (running_q) begin
									idx_q   <= '0;
									state_q <= S_TICK;
								end
							end
							CMD_READ: begin
								if (id_ok) begin
									state_q <= S_READ;
								end else begin
									res_status_q <= ST_BAD_READ;
								end
							end
							CMD_WRITE: begin
								if (!id_ok) begin
									res_status_q <= ST_BAD_WRITE;
								end
							end
							CMD_START: running_q <= 1'b1;
							CMD_STOP:  running_q <= 1'b0;
							CMD_CLEAR: valid_q   <= '0;
							default:   res_status_q <= ST_BAD_CMD;
						endcase
					end
				end
				S_READ: begin
					res_value_q <= cur_value;
					state_q     <= S_DONE;
				end
				S_TICK: begin
					idx_q <= idx_q + ID_W'(1);
					if (last_idx) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						read_value_q <= res_value_q;
						status_q     <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (read_value == '0))
		else $error("error result carries nonzero read_value");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted while another is in flight");

	a_start_sets_run: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_START) |=> running_q)
		else $error("start did not set running flag");

	a_tick_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && ram_we) |-> (ram_waddr != ram_raddr))
		else $error("tick write-back collides with read address");

endmodule

// ===== src/stb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module stb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
